// File: design/fcr_pkg.sv
// Shared types and constants for the framed command receiver.
package fcr_pkg;

    // Identity bytes sent in reply to the identification command
    localparam logic [7:0] ID_BYTE_0    = 8'h00;
    localparam logic [7:0] ID_BYTE_1    = 8'h03;
    localparam logic [7:0] ID_BYTE_HI   = 8'h1e;
    localparam logic [7:0] ID_BYTE_LO   = 8'h4f;
    localparam logic [7:0] TIMEOUT_CHAR = 8'h78;

    // Most beats that one input item can cause
    localparam int MAX_RESULTS = 5;
    localparam int IDX_W       = $clog2(MAX_RESULTS);

    // Default depth of the job queue between front and back
    localparam int QUEUE_DEPTH = 4;

    // Configuration register reset values
    localparam logic [7:0]  RST_SYNC_BYTE    = 8'd0;
    localparam logic [7:0]  RST_WHO_CODE     = 8'd1;
    localparam logic [7:0]  RST_IN_USE_CODE  = 8'd2;
    localparam logic [7:0]  RST_UNLOCK_CODE  = 8'd3;
    localparam logic [7:0]  RST_LOCKED_CODE  = 8'd4;
    localparam logic [7:0]  RST_NODE_ADDRESS = 8'd79;
    localparam logic [15:0] RST_TIMEOUT_MS   = 16'd1000;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SYNC_BYTE    = 3'd0,
        CFG_WHO_CODE     = 3'd1,
        CFG_IN_USE_CODE  = 3'd2,
        CFG_UNLOCK_CODE  = 3'd3,
        CFG_LOCKED_CODE  = 3'd4,
        CFG_NODE_ADDRESS = 3'd5,
        CFG_TIMEOUT_MS   = 3'd6
    } t_cfg_idx;

    typedef struct packed {
        logic [7:0]  sync_byte;
        logic [7:0]  who_code;
        logic [7:0]  in_use_code;
        logic [7:0]  unlock_code;
        logic [7:0]  locked_code;
        logic [7:0]  node_address;
        logic [15:0] timeout_ms;
    } t_cfg;

    // Input beat: a received byte or a millisecond tick
    typedef struct packed {
        logic       mode;
        logic [7:0] rx_byte;
        logic       populated;
        logic       door_closed;
    } t_in;

    localparam logic MODE_BYTE = 1'b0;
    localparam logic MODE_TICK = 1'b1;

    typedef struct packed {
        logic [7:0] tx_byte;
        logic       last;
        logic       unlock_strobe;
    } t_out;

    // Frame receive phase
    typedef enum logic [2:0] {
        PH_IDLE   = 3'd0,
        PH_START1 = 3'd1,
        PH_START2 = 3'd2,
        PH_CMD    = 3'd3,
        PH_ADDR   = 3'd4
    } t_phase;

    typedef enum logic [1:0] {
        CMD_WHO    = 2'd0,
        CMD_IN_USE = 2'd1,
        CMD_UNLOCK = 2'd2,
        CMD_LOCKED = 2'd3
    } t_cmd;

    // What the back end has to send for one accepted item
    typedef enum logic [1:0] {
        JOB_ECHO    = 2'd0,
        JOB_WHO     = 2'd1,
        JOB_REPLY   = 2'd2,
        JOB_TIMEOUT = 2'd3
    } t_job_kind;

    typedef struct packed {
        t_job_kind  kind;
        logic [7:0] echo;
        logic [7:0] addr;
        logic [7:0] reply;
        logic       strobe;
    } t_job;

endpackage

// File: design/fcr_front.sv
// Front end: accepts input beats, tracks the frame and queues output jobs.
module fcr_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  fcr_pkg::t_in  i_in,
    output logic          o_in_stall,
    input  fcr_pkg::t_cfg i_cfg,
    input  logic          i_q_full,
    output logic          o_push,
    output fcr_pkg::t_job o_job
);
    import fcr_pkg::*;

    t_phase      r_phase, n_phase;
    t_cmd        r_cmd, n_cmd;
    logic [15:0] r_elapsed, n_elapsed;
    logic        r_running, n_running;

    logic        w_accept;
    logic [15:0] w_tick_cnt;
    logic        w_timeout;
    logic        w_is_start;
    logic        w_cmd_hit;
    t_cmd        w_cmd_code;
    logic        w_addr_hit;

    assign o_in_stall = i_q_full;
    assign w_accept   = i_in_valid && !i_q_full;

    // Saturating tick count and timeout check
    assign w_tick_cnt = (r_running && (r_elapsed != '1)) ? r_elapsed + 16'd1 : r_elapsed;
    assign w_timeout  = (w_tick_cnt > i_cfg.timeout_ms) && (r_phase != PH_IDLE);

    assign w_is_start = (i_in.rx_byte == i_cfg.sync_byte);
    assign w_addr_hit = (i_in.rx_byte == i_cfg.node_address);

    // Decode command, earlier codes win
    always_comb begin
        w_cmd_hit  = 1'b1;
        w_cmd_code = CMD_WHO;
        priority if (i_in.rx_byte == i_cfg.who_code) begin
            w_cmd_code = CMD_WHO;
        end else if (i_in.rx_byte == i_cfg.in_use_code) begin
            w_cmd_code = CMD_IN_USE;
        end else if (i_in.rx_byte == i_cfg.unlock_code) begin
            w_cmd_code = CMD_UNLOCK;
        end else if (i_in.rx_byte == i_cfg.locked_code) begin
            w_cmd_code = CMD_LOCKED;
        end else begin
            w_cmd_hit = 1'b0;
        end
    end

    // Next frame state
    always_comb begin
        n_phase   = r_phase;
        n_cmd     = r_cmd;
        n_elapsed = r_elapsed;
        n_running = r_running;
        if (w_accept) begin
            if (i_in.mode == MODE_TICK) begin
                n_elapsed = w_tick_cnt;
                if (w_timeout) begin
                    n_phase   = PH_IDLE;
                    n_elapsed = '0;
                    n_running = 1'b0;
                end
            end else begin
                unique case (r_phase)
                    PH_IDLE: begin
                        if (w_is_start) begin
                            n_phase   = PH_START1;
                            n_elapsed = '0;
                            n_running = 1'b1;
                        end
                    end
                    PH_START1: begin
                        if (w_is_start) n_phase = PH_START2;
                    end
                    PH_START2: begin
                        if (w_is_start) n_phase = PH_CMD;
                    end
                    PH_CMD: begin
                        if (w_cmd_hit) begin
                            n_cmd = w_cmd_code;
                            if (w_cmd_code == CMD_WHO) begin
                                n_phase   = PH_IDLE;
                                n_elapsed = '0;
                                n_running = 1'b0;
                            end else begin
                                n_phase = PH_ADDR;
                            end
                        end
                    end
                    PH_ADDR: begin
                        n_phase   = PH_IDLE;
                        n_elapsed = '0;
                        n_running = 1'b0;
                    end
                    default: begin
                        n_phase = PH_IDLE;
                    end
                endcase
            end
        end
    end

    // Job for the back end
    always_comb begin
        o_push       = 1'b0;
        o_job.kind   = JOB_ECHO;
        o_job.echo   = i_in.rx_byte;
        o_job.addr   = i_cfg.node_address;
        o_job.reply  = '0;
        o_job.strobe = 1'b0;
        if (w_accept) begin
            if (i_in.mode == MODE_TICK) begin
                o_push     = w_timeout;
                o_job.kind = JOB_TIMEOUT;
            end else begin
                o_push = 1'b1;
                if ((r_phase == PH_CMD) && w_cmd_hit && (w_cmd_code == CMD_WHO)) begin
                    o_job.kind = JOB_WHO;
                end else if (r_phase == PH_ADDR) begin
                    if (r_cmd == CMD_WHO) begin
                        o_job.kind = JOB_WHO;
                    end else if (w_addr_hit) begin
                        o_job.kind = JOB_REPLY;
                        unique case (r_cmd)
                            CMD_IN_USE: o_job.reply = {7'd0, i_in.populated};
                            CMD_UNLOCK: begin
                                o_job.reply  = i_cfg.unlock_code;
                                o_job.strobe = 1'b1;
                            end
                            default:    o_job.reply = {7'd0, i_in.door_closed};
                        endcase
                    end
                end
            end
        end
    end

    // Frame state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_IDLE;
            r_cmd     <= CMD_WHO;
            r_elapsed <= '0;
            r_running <= 1'b0;
        end else begin
            r_phase   <= n_phase;
            r_cmd     <= n_cmd;
            r_elapsed <= n_elapsed;
            r_running <= n_running;
        end
    end

    // Timer only runs inside a frame
    a_run_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_running |-> (r_phase != PH_IDLE))
        else $error("frame timer running while idle");

    // A stopped timer holds zero
    a_stopped_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_running |-> (r_elapsed == '0))
        else $error("stopped frame timer not cleared");

    // A tick only ever queues the timeout notice
    a_tick_job: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push && (i_in.mode == MODE_TICK)) |-> (o_job.kind == JOB_TIMEOUT))
        else $error("tick queued a job other than timeout");

endmodule

// File: design/fcr_queue.sv
// Job queue between the front and back ends.
module fcr_queue #(
    parameter int DEPTH = fcr_pkg::QUEUE_DEPTH
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  fcr_pkg::t_job i_job,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_valid,
    output fcr_pkg::t_job o_job
);
    import fcr_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_job          r_mem [DEPTH];
    logic [PW-1:0] r_wr, n_wr;
    logic [PW-1:0] r_rd, n_rd;
    logic [CW-1:0] r_count, n_count;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_job   = r_mem[r_rd];

    // Advance pointers with wrap at the depth
    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (i_push) n_wr = (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        if (i_pop)  n_rd = (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        if (i_push && !i_pop) n_count = r_count + 1'b1;
        if (!i_push && i_pop) n_count = r_count - 1'b1;
    end

    // Store jobs
    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr] <= i_job;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("job pushed into full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid)
        else $error("job popped from empty queue");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("queue count beyond depth");

endmodule

// File: design/fcr_back.sv
// Back end: expands each job into transmit beats behind an output register.
module fcr_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_job_valid,
    input  fcr_pkg::t_job i_job,
    output logic          o_pop,
    input  logic          i_out_stall,
    output logic          o_out_valid,
    output fcr_pkg::t_out o_out
);
    import fcr_pkg::*;

    localparam logic [IDX_W-1:0] LAST_ECHO  = '0;
    localparam logic [IDX_W-1:0] LAST_REPLY = IDX_W'(2);
    localparam logic [IDX_W-1:0] LAST_WHO   = IDX_W'(MAX_RESULTS - 1);

    t_job             r_job;
    logic             r_busy;
    logic [IDX_W-1:0] r_idx;
    logic             r_out_valid;
    t_out             r_out;

    logic             w_advance;
    logic             w_load;
    logic             w_take;
    logic [IDX_W-1:0] w_last_idx;
    logic             w_cur_last;
    t_out             w_cur;

    // Pick the beat at the current index
    always_comb begin
        w_cur.tx_byte       = r_job.echo;
        w_cur.unlock_strobe = 1'b0;
        w_last_idx          = LAST_ECHO;
        unique case (r_job.kind)
            JOB_ECHO: begin
                w_last_idx = LAST_ECHO;
            end
            JOB_WHO: begin
                w_last_idx = LAST_WHO;
                unique case (r_idx)
                    IDX_W'(1): w_cur.tx_byte = ID_BYTE_0;
                    IDX_W'(2): w_cur.tx_byte = ID_BYTE_1;
                    IDX_W'(3): w_cur.tx_byte = ID_BYTE_HI;
                    IDX_W'(4): w_cur.tx_byte = ID_BYTE_LO;
                    default:   w_cur.tx_byte = r_job.echo;
                endcase
            end
            JOB_REPLY: begin
                w_last_idx = LAST_REPLY;
                if (r_idx == IDX_W'(1)) begin
                    w_cur.tx_byte = r_job.addr;
                end else if (r_idx == LAST_REPLY) begin
                    w_cur.tx_byte       = r_job.reply;
                    w_cur.unlock_strobe = r_job.strobe;
                end
            end
            default: begin
                w_last_idx    = LAST_REPLY;
                w_cur.tx_byte = TIMEOUT_CHAR;
            end
        endcase
        w_cur.last = (r_idx == w_last_idx);
    end

    assign w_cur_last = (r_idx == w_last_idx);

    // Output register moves when empty or taken
    assign w_advance = !r_out_valid || !i_out_stall;
    assign w_load    = w_advance && r_busy;
    assign w_take    = i_job_valid && (!r_busy || (w_load && w_cur_last));
    assign o_pop     = w_take;

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // Hold the job being expanded and load the output register
    always_ff @(posedge i_clk) begin
        if (w_take) r_job <= i_job;
        if (w_advance) r_out <= w_cur;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_take) begin
                r_busy <= 1'b1;
                r_idx  <= '0;
            end else if (w_load) begin
                if (w_cur_last) begin
                    r_busy <= 1'b0;
                    r_idx  <= '0;
                end else begin
                    r_idx <= r_idx + 1'b1;
                end
            end
            if (w_advance) r_out_valid <= r_busy;
        end
    end

    a_idle_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_busy |-> (r_idx == '0))
        else $error("beat index not cleared while idle");

    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_idx <= w_last_idx))
        else $error("beat index past end of job");

    a_strobe_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.unlock_strobe) |-> r_out.last)
        else $error("unlock strobe on a beat that is not last");

endmodule

// File: design/framed_command_receiver.sv
// Top level of the framed command receiver: config registers, front, queue, back.
//
//  channel | direction | handshake             | payload
//  in      | to block  | i_in_valid/o_in_stall | i_in_data (t_in)
//  out     | from block| o_out_valid/i_out_stall | o_out_data (t_out)
//  cfg     | to block  | i_cfg_valid/o_cfg_ready | i_cfg_index, i_cfg_data
//
// The front takes one beat per cycle while the job queue has room; the back sends
// one beat per cycle while the output is not stalled, so an item takes one beat
// for an echo, three for an addressed reply or timeout and five for identification.
// The first beat of an item passes the job queue, job register and output register.
// Reset is synchronous, active low, and restores the register defaults.
// A stall at the output fills the queue, which then stalls the input.
module framed_command_receiver #(
    parameter int QDEPTH = fcr_pkg::QUEUE_DEPTH
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    input  fcr_pkg::t_in                        i_in_data,
    output logic                                o_in_stall,
    output logic                                o_out_valid,
    output fcr_pkg::t_out                       o_out_data,
    input  logic                                i_out_stall,
    input  logic                                i_cfg_valid,
    input  logic [fcr_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [fcr_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    output logic                                o_cfg_ready
);
    import fcr_pkg::*;

    t_cfg r_cfg;
    logic w_q_full;
    logic w_push;
    t_job w_push_job;
    logic w_pop;
    logic w_q_valid;
    t_job w_q_job;

    assign o_cfg_ready = 1'b1;

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sync_byte    <= RST_SYNC_BYTE;
            r_cfg.who_code     <= RST_WHO_CODE;
            r_cfg.in_use_code  <= RST_IN_USE_CODE;
            r_cfg.unlock_code  <= RST_UNLOCK_CODE;
            r_cfg.locked_code  <= RST_LOCKED_CODE;
            r_cfg.node_address <= RST_NODE_ADDRESS;
            r_cfg.timeout_ms   <= RST_TIMEOUT_MS;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_SYNC_BYTE:    r_cfg.sync_byte    <= i_cfg_data[7:0];
                CFG_WHO_CODE:     r_cfg.who_code     <= i_cfg_data[7:0];
                CFG_IN_USE_CODE:  r_cfg.in_use_code  <= i_cfg_data[7:0];
                CFG_UNLOCK_CODE:  r_cfg.unlock_code  <= i_cfg_data[7:0];
                CFG_LOCKED_CODE:  r_cfg.locked_code  <= i_cfg_data[7:0];
                CFG_NODE_ADDRESS: r_cfg.node_address <= i_cfg_data[7:0];
                CFG_TIMEOUT_MS:   r_cfg.timeout_ms   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    fcr_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in       (i_in_data),
        .o_in_stall (o_in_stall),
        .i_cfg      (r_cfg),
        .i_q_full   (w_q_full),
        .o_push     (w_push),
        .o_job      (w_push_job)
    );

    fcr_queue #(
        .DEPTH (QDEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_push_job),
        .o_full  (w_q_full),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_job   (w_q_job)
    );

    fcr_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (w_q_valid),
        .i_job       (w_q_job),
        .o_pop       (w_pop),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out       (o_out_data)
    );

endmodule
